// ----- rtl/bsp_pkg.sv -----
`timescale 1ns / 1ps

package bsp_pkg;

    // field widths
    localparam int IDX_W   = 9;
    localparam int POS_W   = 10;
    localparam int LEN_W   = 7;
    localparam int COLOR_W = 24;
    localparam int CH_W    = 8;
    localparam int SEL_W   = 3;
    localparam int CFG_W   = 24;
    // signed working width for position math
    localparam int AW      = 12;

    localparam int LED_COUNT_DEF = 300;

    // register indexes
    localparam logic [SEL_W-1:0] REG_SECTION_LENGTH   = 3'd0;
    localparam logic [SEL_W-1:0] REG_BACKGROUND_COLOR = 3'd1;
    localparam logic [SEL_W-1:0] REG_STRIPE_COLOR_A   = 3'd2;
    localparam logic [SEL_W-1:0] REG_STRIPE_COLOR_B   = 3'd3;
    localparam logic [SEL_W-1:0] REG_STRIPE_COLOR_C   = 3'd4;

    // register reset values
    localparam logic [LEN_W-1:0]   RST_SECTION_LENGTH   = 7'd15;
    localparam logic [COLOR_W-1:0] RST_BACKGROUND_COLOR = 24'h0A2AC8;
    localparam logic [COLOR_W-1:0] RST_STRIPE_COLOR_A   = 24'h0A280A;
    localparam logic [COLOR_W-1:0] RST_STRIPE_COLOR_B   = 24'h1E280A;
    localparam logic [COLOR_W-1:0] RST_STRIPE_COLOR_C   = 24'h191E0F;

    // item modes
    localparam logic MODE_MOVE  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] background;
        logic [COLOR_W-1:0] stripe_a;
        logic [COLOR_W-1:0] stripe_b;
        logic [COLOR_W-1:0] stripe_c;
    } cfg_t;

    // offset modulo three by folding base-4 digits (4 = 1 mod 3)
    function automatic logic [1:0] mod3(input logic [LEN_W-1:0] x);
        logic [3:0] s1;
        logic [2:0] s2;
        logic [1:0] res;
        s1 = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]} + {3'b000, x[6]};
        s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]};
        if (s2 >= 3'd3)
        begin
            s2 = s2 - 3'd3;
        end
        res = s2[1:0];
        return res;
    endfunction

endpackage

// ----- rtl/bsp_in_if.sv -----
`timescale 1ns / 1ps

interface bsp_in_if;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [bsp_pkg::IDX_W-1:0] pixel_index;

    modport source (output valid, output mode, output pixel_index, input ready);
    modport sink   (input valid, input mode, input pixel_index, output ready);
endinterface

// ----- rtl/bsp_out_if.sv -----
`timescale 1ns / 1ps

interface bsp_out_if;
    logic                      valid;
    logic                      ready;
    logic [bsp_pkg::IDX_W-1:0] led_position;
    logic [bsp_pkg::CH_W-1:0]  red;
    logic [bsp_pkg::CH_W-1:0]  green;
    logic [bsp_pkg::CH_W-1:0]  blue;

    modport source (output valid, output led_position, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input led_position, input red, input green,
                    input blue, output ready);
endinterface

// ----- rtl/bouncing_segment_pair_pattern_top.sv -----
`timescale 1ns / 1ps

// Bouncing segment pair renderer: two striped segments of section_length LEDs
// run toward each other on a strip of LED_COUNT pixels, turn around when they
// meet and bounce off the strip ends. A request with mode 0 advances both
// segments one step and returns nothing; a request with mode 1 returns the
// color of the LED at pixel_index (right segment over left, left over the
// background, stripes chosen by the offset from the segment's outer end
// modulo three). Every request passes the input register; a pixel then also
// passes the result register. One request can be taken every cycle while the
// result register is not stalled; it drains while the next request is taken.
// Configuration registers are to be written through cfg_we / cfg_index /
// cfg_data by the user only while no request is in flight, which the block
// does not enforce; indexes beyond the register list are ignored.

module bouncing_segment_pair_pattern_top #(
    parameter int LED_COUNT = bsp_pkg::LED_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bsp_pkg::SEL_W-1:0] cfg_index,
    input  logic [bsp_pkg::CFG_W-1:0] cfg_data,
    bsp_in_if.sink                    in_ch,
    bsp_out_if.source                 out_ch
);
    import bsp_pkg::*;

    cfg_t cfg;

    // input register stage
    logic             s1_valid_reg;
    logic             s1_mode_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    // result register stage
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_pos_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic               s1_fire;
    logic               move_step;
    logic [POS_W-1:0]   left_start, right_start;
    logic [COLOR_W-1:0] pix_color;

    // a move leaves the input stage at once; a pixel waits for room in the
    // result register
    assign s1_fire   = s1_valid_reg &&
                       ((s1_mode_reg == MODE_MOVE) || !out_valid_reg || out_ch.ready);
    assign move_step = s1_fire && (s1_mode_reg == MODE_MOVE);

    assign in_ch.ready = !s1_valid_reg || s1_fire;

    bsp_cfg_regs #(.LED_COUNT(LED_COUNT)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // segment positions and directions, updated in request order
    bsp_motion #(.LED_COUNT(LED_COUNT)) u_motion (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (move_step),
        .len         (cfg.len),
        .left_start  (left_start),
        .right_start (right_start)
    );

    // color lookup against the current positions
    bsp_pixel #(.LED_COUNT(LED_COUNT)) u_pixel (
        .pixel_index (s1_idx_reg),
        .left_start  (left_start),
        .right_start (right_start),
        .cfg         (cfg),
        .color       (pix_color)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_mode_reg <= in_ch.mode;
            s1_idx_reg  <= in_ch.pixel_index;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && (s1_mode_reg == MODE_PIXEL))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && (s1_mode_reg == MODE_PIXEL))
        begin
            out_pos_reg   <= s1_idx_reg;
            out_color_reg <= pix_color;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.led_position = out_pos_reg;
    assign out_ch.red          = out_color_reg[23:16];
    assign out_ch.green        = out_color_reg[15:8];
    assign out_ch.blue         = out_color_reg[7:0];

endmodule

// ----- rtl/bsp_cfg_regs.sv -----
`timescale 1ns / 1ps

module bsp_cfg_regs #(
    parameter int LED_COUNT = bsp_pkg::LED_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bsp_pkg::SEL_W-1:0]   cfg_index,
    input  logic [bsp_pkg::CFG_W-1:0]   cfg_data,
    output bsp_pkg::cfg_t               cfg
);
    import bsp_pkg::*;

    localparam int HALF = LED_COUNT / 2;

    logic [LEN_W-1:0]   section_length_reg;
    logic [COLOR_W-1:0] background_reg;
    logic [COLOR_W-1:0] stripe_a_reg;
    logic [COLOR_W-1:0] stripe_b_reg;
    logic [COLOR_W-1:0] stripe_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_length_reg <= RST_SECTION_LENGTH;
            background_reg     <= RST_BACKGROUND_COLOR;
            stripe_a_reg       <= RST_STRIPE_COLOR_A;
            stripe_b_reg       <= RST_STRIPE_COLOR_B;
            stripe_c_reg       <= RST_STRIPE_COLOR_C;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SECTION_LENGTH:   section_length_reg <= cfg_data[LEN_W-1:0];
                REG_BACKGROUND_COLOR: background_reg     <= cfg_data[COLOR_W-1:0];
                REG_STRIPE_COLOR_A:   stripe_a_reg       <= cfg_data[COLOR_W-1:0];
                REG_STRIPE_COLOR_B:   stripe_b_reg       <= cfg_data[COLOR_W-1:0];
                REG_STRIPE_COLOR_C:   stripe_c_reg       <= cfg_data[COLOR_W-1:0];
                default:              ;
            endcase
        end
    end

    // length saturated to 1 .. half the strip
    always_comb
    begin
        cfg.len = section_length_reg;
        if (section_length_reg == '0)
        begin
            cfg.len = LEN_W'(1);
        end
        else if (int'(section_length_reg) > HALF)
        begin
            cfg.len = LEN_W'(HALF);
        end
        cfg.background = background_reg;
        cfg.stripe_a   = stripe_a_reg;
        cfg.stripe_b   = stripe_b_reg;
        cfg.stripe_c   = stripe_c_reg;
    end

endmodule

// ----- rtl/bsp_motion.sv -----
`timescale 1ns / 1ps

module bsp_motion #(
    parameter int LED_COUNT = bsp_pkg::LED_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [bsp_pkg::LEN_W-1:0] len,
    output logic [bsp_pkg::POS_W-1:0] left_start,
    output logic [bsp_pkg::POS_W-1:0] right_start
);
    import bsp_pkg::*;

    localparam logic signed [AW-1:0] CNT_S = AW'(LED_COUNT);
    localparam logic signed [AW-1:0] ONE_S = AW'(1);

    logic [POS_W-1:0] left_reg, left_next;
    logic [POS_W-1:0] right_reg, right_next;
    logic             left_down_reg, left_down_next;
    logic             right_down_reg, right_down_next;

    logic signed [AW-1:0] len_s, l_s, r_s;

    always_comb
    begin
        len_s = $signed({{(AW-LEN_W){1'b0}}, len});
        l_s   = $signed({{(AW-POS_W){1'b0}}, left_reg}) + (left_down_reg ? -ONE_S : ONE_S);
        r_s   = $signed({{(AW-POS_W){1'b0}}, right_reg}) + (right_down_reg ? -ONE_S : ONE_S);

        left_down_next  = left_down_reg;
        right_down_next = right_down_reg;

        // inner edges meet or cross: both turn around
        if (l_s + len_s - ONE_S >= r_s - len_s + ONE_S)
        begin
            left_down_next  = ~left_down_reg;
            right_down_next = ~right_down_reg;
        end

        // left wall clamps
        if (l_s < 0)
        begin
            l_s            = '0;
            left_down_next = 1'b0;
        end
        else if (l_s > CNT_S - len_s)
        begin
            l_s            = CNT_S - len_s;
            left_down_next = 1'b1;
        end

        // right wall clamps
        if (r_s < len_s - ONE_S)
        begin
            r_s             = len_s - ONE_S;
            right_down_next = 1'b0;
        end
        else if (r_s > CNT_S - ONE_S)
        begin
            r_s             = CNT_S - ONE_S;
            right_down_next = 1'b1;
        end

        left_next  = l_s[POS_W-1:0];
        right_next = r_s[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            right_reg      <= POS_W'(LED_COUNT - 1);
            left_down_reg  <= 1'b0;
            right_down_reg <= 1'b1;
        end
        else if (step)
        begin
            left_reg       <= left_next;
            right_reg      <= right_next;
            left_down_reg  <= left_down_next;
            right_down_reg <= right_down_next;
        end
    end

    assign left_start  = left_reg;
    assign right_start = right_reg;

endmodule

// ----- rtl/bsp_pixel.sv -----
`timescale 1ns / 1ps

module bsp_pixel #(
    parameter int LED_COUNT = bsp_pkg::LED_COUNT_DEF
) (
    input  logic [bsp_pkg::IDX_W-1:0]   pixel_index,
    input  logic [bsp_pkg::POS_W-1:0]   left_start,
    input  logic [bsp_pkg::POS_W-1:0]   right_start,
    input  bsp_pkg::cfg_t               cfg,
    output logic [bsp_pkg::COLOR_W-1:0] color
);
    import bsp_pkg::*;

    localparam logic signed [AW-1:0] CNT_S = AW'(LED_COUNT);

    logic signed [AW-1:0] p_s, len_s, dr, dl;
    logic                 hit_r, hit_l;

    function automatic logic [COLOR_W-1:0] stripe(input logic [LEN_W-1:0] off, input cfg_t c);
        logic [1:0] r;
        logic [COLOR_W-1:0] col;
        r = mod3(off);
        case (r)
            2'd0:    col = c.stripe_a;
            2'd1:    col = c.stripe_b;
            default: col = c.stripe_c;
        endcase
        return col;
    endfunction

    always_comb
    begin
        p_s   = $signed({{(AW-IDX_W){1'b0}}, pixel_index});
        len_s = $signed({{(AW-LEN_W){1'b0}}, cfg.len});
        dr    = $signed({{(AW-POS_W){1'b0}}, right_start}) - p_s;
        dl    = p_s - $signed({{(AW-POS_W){1'b0}}, left_start});
        hit_r = (dr >= 0) && (dr < len_s);
        hit_l = (dl >= 0) && (dl < len_s);

        if (p_s >= CNT_S)
        begin
            color = cfg.background;
        end
        else if (hit_r)
        begin
            color = stripe(dr[LEN_W-1:0], cfg);
        end
        else if (hit_l)
        begin
            color = stripe(dl[LEN_W-1:0], cfg);
        end
        else
        begin
            color = cfg.background;
        end
    end

endmodule
